@@ src/ntit_pkg.sv @@
package ntit_pkg;

	localparam int TABLE_BITS_DEF = 10;

	localparam int ADDR_W     = 32;
	localparam int MODE_W     = 3;
	localparam int TS_W       = 64;
	localparam int IN_DATA_W  = 456;
	localparam int OUT_DATA_W = 192;
	localparam int ENTRY_W    = 2 * TS_W;

	localparam logic [ADDR_W-1:0] HASH_MULT   = 32'hDE9DB139;
	localparam logic [MODE_W-1:0] CLIENT_MODE = 3'd3;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_SERVE  = 1'b1;

	typedef struct packed {
		logic load_in;
		logic hash;
		logic mem_wr;
		logic mem_rd;
		logic clear_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_serve;
		logic req_ok;
		logic clear_last;
		logic out_free;
	} sts_t;

endpackage

@@ src/ntit_ram.sv @@
module ntit_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/ntit_ctrl.sv @@
module ntit_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  ntit_pkg::sts_t     sts,
	output ntit_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_HASH   = 3'd2;
	localparam logic [2:0] ST_ACCESS = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash = 1'b1;
				state_d  = ST_ACCESS;
			end
			ST_ACCESS: begin
				if (!sts.is_serve) begin
					cmd.mem_wr = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.req_ok) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_RESULT;
				end else begin
					// drop filtered request
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

@@ src/ntit_datapath.sv @@
module ntit_datapath #(
	parameter int TABLE_BITS = ntit_pkg::TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ntit_pkg::ADDR_W-1:0]         cfg_wdata,
	input  logic [ntit_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ntit_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [0:0]                          m_tuser,
	input  ntit_pkg::cmd_t                      cmd,
	output ntit_pkg::sts_t                      sts
);

	localparam int DEPTH = 1 << TABLE_BITS;

	logic [ntit_pkg::ADDR_W-1:0] own_q;
	logic [TABLE_BITS-1:0]       clr_cnt_q;
	logic                        out_valid_q;

	logic                        op_q;
	logic [ntit_pkg::ADDR_W-1:0] client_q;
	logic [ntit_pkg::ADDR_W-1:0] dest_q;
	logic [ntit_pkg::MODE_W-1:0] mode_q;
	logic [ntit_pkg::TS_W-1:0]   org_q;
	logic [ntit_pkg::TS_W-1:0]   rrx_q;
	logic [ntit_pkg::TS_W-1:0]   rtx_q;
	logic [ntit_pkg::TS_W-1:0]   lrx_q;
	logic [ntit_pkg::TS_W-1:0]   now_q;
	logic [ntit_pkg::TS_W-1:0]   hwtx_q;
	logic [TABLE_BITS-1:0]       cell_q;

	logic [ntit_pkg::ADDR_W-1:0]   prod;
	logic                          mem_we;
	logic [TABLE_BITS-1:0]         mem_waddr;
	logic [ntit_pkg::ENTRY_W-1:0]  mem_wdata;
	logic [ntit_pkg::ENTRY_W-1:0]  mem_rdata;
	logic [ntit_pkg::TS_W-1:0]     stored_rx;
	logic [ntit_pkg::TS_W-1:0]     stored_tx;
	logic                          xl;

	logic                          xl_q;
	logic [ntit_pkg::TS_W-1:0]     org_out_q;
	logic [ntit_pkg::TS_W-1:0]     rx_out_q;
	logic [ntit_pkg::TS_W-1:0]     tx_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (cmd.clear_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= s_tuser[0];
			client_q <= s_tdata[31:0];
			dest_q   <= s_tdata[63:32];
			mode_q   <= s_tdata[66:64];
			org_q    <= s_tdata[130:67];
			rrx_q    <= s_tdata[194:131];
			rtx_q    <= s_tdata[258:195];
			lrx_q    <= s_tdata[322:259];
			now_q    <= s_tdata[386:323];
			hwtx_q   <= s_tdata[450:387];
		end
	end

	// multiplicative hash: top bits of the low 32-bit product word
	assign prod = client_q * ntit_pkg::HASH_MULT;

	always_ff @(posedge clk) begin
		if (cmd.hash) begin
			cell_q <= prod[ntit_pkg::ADDR_W-1 -: TABLE_BITS];
		end
	end

	assign mem_we    = cmd.clear_wr | cmd.mem_wr;
	assign mem_waddr = cmd.clear_wr ? clr_cnt_q : cell_q;
	assign mem_wdata = cmd.clear_wr ? '0 : {hwtx_q, lrx_q};

	ntit_ram #(
		.WIDTH (ntit_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.mem_rd),
		.raddr (cell_q),
		.rdata (mem_rdata)
	);

	assign stored_rx = mem_rdata[ntit_pkg::TS_W-1:0];
	assign stored_tx = mem_rdata[ntit_pkg::ENTRY_W-1:ntit_pkg::TS_W];

	assign xl = (org_q != '0) && (rrx_q != rtx_q) && (org_q == stored_rx);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			xl_q      <= xl;
			org_out_q <= xl ? rrx_q : rtx_q;
			rx_out_q  <= lrx_q;
			tx_out_q  <= xl ? stored_tx : now_q;
		end
	end

	assign sts.is_serve   = (op_q == ntit_pkg::OP_SERVE);
	assign sts.req_ok     = (dest_q == own_q) && (client_q != own_q) &&
		(mode_q == ntit_pkg::CLIENT_MODE);
	assign sts.clear_last = &clr_cnt_q;
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {tx_out_q, rx_out_q, org_out_q};
	assign m_tuser  = xl_q;

endmodule

@@ src/ntp_interleaved_timestamp_table.sv @@
// Serve request: the input transfer is followed by the hash, table read and result steps.
// Items are taken one at a time: s_tready is high only in idle, which a record item or a
// dropped request reaches after the table access, a serve after its result is loaded.
// Reset: arst_n clears control state and own_address, then a clearing pass zeroes all
// 2^TABLE_BITS table entries with s_tready low; cfg writes are taken meanwhile.
module ntp_interleaved_timestamp_table #(
	parameter int TABLE_BITS = ntit_pkg::TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ntit_pkg::ADDR_W-1:0]      cfg_wdata,   // own_address
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// client_address, destination_address, request_mode, request_origin_time,
	// request_receive_time, request_transmit_time, local_receive_time,
	// current_time, hardware_transmit_time, zero pad
	input  logic [ntit_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [0:0]                       s_tuser,     // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// reply_origin_time, reply_receive_time, reply_transmit_time
	output logic [ntit_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [0:0]                       m_tuser      // interleaved
);

	ntit_pkg::cmd_t cmd;
	ntit_pkg::sts_t sts;

	ntit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ntit_datapath #(
		.TABLE_BITS (TABLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef SYNTH
	a_out_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.load_out))
		else $error("m_tvalid rose without a result load");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !s_tready)
		else $error("input ready during table clearing");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken result");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a transfer");
`endif

endmodule

@@ bench/ntp_reply_checker.sv @@
module ntp_reply_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ntit_pkg::ADDR_W-1:0]     cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [ntit_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [0:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [ntit_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [0:0]                      m_tuser,
	output int                              errors,
	output int                              pending
);
	import ntit_pkg::*;

	localparam int SLOT_BITS = TABLE_BITS_DEF;
	localparam int SLOTS     = 1 << SLOT_BITS;

	typedef struct packed {
		logic            interleaved;
		logic [TS_W-1:0] origin;
		logic [TS_W-1:0] receive;
		logic [TS_W-1:0] transmit;
	} reply_t;

	logic [TS_W-1:0]   rx_stamp [SLOTS];
	logic [TS_W-1:0]   tx_stamp [SLOTS];
	logic [ADDR_W-1:0] own_addr;
	reply_t            reply_q [$];

	function automatic logic [SLOT_BITS-1:0] slot_of(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W-1:0] prod;
		prod = addr * HASH_MULT;
		return prod[ADDR_W-1 -: SLOT_BITS];
	endfunction

	// Returns 1 when the request passes the filter; fills in the reply it must produce.
	function automatic logic build_reply(input logic [IN_DATA_W-1:0] d, output reply_t rep);
		logic [ADDR_W-1:0]  client, dest;
		logic [MODE_W-1:0]  mode;
		logic [TS_W-1:0]    org, rrx, rtx, lrx, now;
		logic [SLOT_BITS-1:0] slot;
		logic               hit;
		client = d[31:0];
		dest   = d[63:32];
		mode   = d[66:64];
		org    = d[130:67];
		rrx    = d[194:131];
		rtx    = d[258:195];
		lrx    = d[322:259];
		now    = d[386:323];
		slot   = slot_of(client);
		rep    = '0;
		if (dest != own_addr || client == own_addr || mode != CLIENT_MODE)
			return 1'b0;
		hit = (org != '0) && (rrx != rtx) && (org == rx_stamp[slot]);
		rep.interleaved = hit;
		rep.origin      = hit ? rrx : rtx;
		rep.receive     = lrx;
		rep.transmit    = hit ? tx_stamp[slot] : now;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want, got;
		logic [SLOT_BITS-1:0] slot;
		if (!arst_n) begin
			own_addr <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				rx_stamp[i] <= '0;
				tx_stamp[i] <= '0;
			end
			reply_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				own_addr <= cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_RECORD) begin
					slot = slot_of(s_tdata[31:0]);
					rx_stamp[slot] <= s_tdata[322:259];
					tx_stamp[slot] <= s_tdata[450:387];
				end else if (build_reply(s_tdata, want)) begin
					reply_q.push_back(want);
				end
			end
			if (m_tvalid && m_tready) begin
				got.interleaved = m_tuser[0];
				got.origin      = m_tdata[63:0];
				got.receive     = m_tdata[127:64];
				got.transmit    = m_tdata[191:128];
				if (reply_q.size() == 0) begin
					errors = errors + 1;
					if (errors <= 10)
						$display("unexpected reply: il=%0d org=%h rcv=%h xmt=%h",
							got.interleaved, got.origin, got.receive, got.transmit);
				end else begin
					want = reply_q.pop_front();
					if (got !== want) begin
						errors = errors + 1;
						if (errors <= 10) begin
							$display("reply mismatch: expected il=%0d org=%h rcv=%h xmt=%h",
								want.interleaved, want.origin, want.receive, want.transmit);
							$display("                actual   il=%0d org=%h rcv=%h xmt=%h",
								got.interleaved, got.origin, got.receive, got.transmit);
						end
					end
				end
			end
			pending = reply_q.size();
		end
	end

endmodule

@@ bench/tb_ntp_interleaved_timestamp_table.sv @@
module tb_ntp_interleaved_timestamp_table;
	import ntit_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 115;
	localparam int POOL_SIZE   = 16;

	typedef struct {
		logic              op;
		logic [ADDR_W-1:0] client;
		logic [ADDR_W-1:0] dest;
		logic [MODE_W-1:0] mode;
		logic [TS_W-1:0]   org;
		logic [TS_W-1:0]   rrx;
		logic [TS_W-1:0]   rtx;
		logic [TS_W-1:0]   lrx;
		logic [TS_W-1:0]   now;
		logic [TS_W-1:0]   hwtx;
	} ntp_item_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [ADDR_W-1:0]     cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [0:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	int                    errors;
	int                    pending;
	int                    cycles         = 0;
	int unsigned           send_idle_pct  = 0;
	int unsigned           recv_stall_pct = 0;
	logic [ADDR_W-1:0]     own_now        = '0;
	logic [ADDR_W-1:0]     pool    [POOL_SIZE];
	logic [TS_W-1:0]       pool_rx [POOL_SIZE];

	ntp_interleaved_timestamp_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	ntp_reply_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [TS_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Stimulus only: used to find a client that lands in the same slot as another.
	function automatic logic [TABLE_BITS_DEF-1:0] hash_slot(input logic [ADDR_W-1:0] addr);
		logic [ADDR_W-1:0] prod;
		prod = addr * HASH_MULT;
		return prod[ADDR_W-1 -: TABLE_BITS_DEF];
	endfunction

	function automatic ntp_item_t random_item();
		ntp_item_t it;
		it.op     = 1'($urandom_range(1));
		it.client = $urandom;
		it.dest   = $urandom;
		it.mode   = MODE_W'($urandom_range(7));
		it.org    = rand64();
		it.rrx    = rand64();
		it.rtx    = rand64();
		it.lrx    = rand64();
		it.now    = rand64();
		it.hwtx   = rand64();
		return it;
	endfunction

	// Well-formed client request with random content.
	function automatic ntp_item_t serve_item(input logic [ADDR_W-1:0] client,
			input logic [TS_W-1:0] org);
		ntp_item_t it;
		it        = random_item();
		it.op     = OP_SERVE;
		it.client = client;
		it.dest   = own_now;
		it.mode   = CLIENT_MODE;
		it.org    = org;
		if (it.rrx == it.rtx)
			it.rtx = ~it.rrx;
		return it;
	endfunction

	function automatic ntp_item_t record_item(input logic [ADDR_W-1:0] client,
			input logic [TS_W-1:0] lrx, input logic [TS_W-1:0] hwtx);
		ntp_item_t it;
		it        = random_item();
		it.op     = OP_RECORD;
		it.client = client;
		it.lrx    = lrx;
		it.hwtx   = hwtx;
		return it;
	endfunction

	task automatic send_item(input ntp_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {5'b0, it.hwtx, it.now, it.lrx, it.rtx, it.rrx, it.org,
			it.mode, it.dest, it.client};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold the sender off until every reply in flight has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_own(input logic [ADDR_W-1:0] addr);
		drain();
		// record items and dropped requests give no reply; let them finish
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		own_now    = addr;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 62;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 62;
			end
			default: begin
				send_idle_pct  = 31;
				recv_stall_pct = 31;
			end
		endcase
	endtask

	task automatic new_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool[i]    = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
			pool_rx[i] = '0;
			if (pool[i] == own_now)
				pool[i] = pool[i] ^ 32'h1;
		end
	endtask

	task automatic directed();
		ntp_item_t         it;
		logic [ADDR_W-1:0] x, y;
		logic [TS_W-1:0]   r, t, r2, t2;
		x  = 32'h0A00_0005;
		y  = x + 1;
		while (hash_slot(y) != hash_slot(x) || y == own_now)
			y = y + 1;
		r  = rand64() | 64'h1;
		t  = rand64();
		r2 = ~r;
		t2 = rand64();
		// empty slot: zero origin, then a nonzero origin that cannot match
		send_item(serve_item(x, '0));
		send_item(serve_item(x, r));
		send_item(record_item(x, r, t));
		send_item(serve_item(x, r));
		it = serve_item(x, r);
		it.rtx = it.rrx;
		send_item(it);
		// filtered requests
		it = serve_item(x, r);
		it.dest = ~own_now;
		send_item(it);
		send_item(serve_item(own_now, r));
		for (int m = 0; m < 8; m++) begin
			if (m[MODE_W-1:0] != CLIENT_MODE) begin
				it = serve_item(x, r);
				it.mode = m[MODE_W-1:0];
				send_item(it);
			end
		end
		// colliding client overwrites the slot
		send_item(record_item(y, r2, t2));
		send_item(serve_item(x, r2));
		send_item(serve_item(x, r));
		send_item(record_item(x, '0, rand64()));
		send_item(serve_item(x, '0));
		// field extremes
		send_item(record_item('1, '1, '1));
		it = serve_item('1, '1);
		it.rrx = '0;
		it.rtx = '1;
		send_item(it);
		it = serve_item('0, '0);
		it.rrx = '1;
		it.rtx = '1;
		it.lrx = '0;
		it.now = '1;
		send_item(it);
	endtask

	task automatic random_phase(input int n, input bit pause_midway);
		ntp_item_t it;
		int        done;
		int        k;
		int        pick;
		bit        paused;
		done   = 0;
		paused = 1'b0;
		while (done < n) begin
			if (pause_midway && !paused && done >= n / 2) begin
				drain();
				paused = 1'b1;
			end
			k    = $urandom_range(POOL_SIZE - 1);
			pick = $urandom_range(99);
			if (pick < 35) begin
				it = record_item(pool[k], rand64(), rand64());
				pool_rx[k] = it.lrx;
			end else if (pick < 65) begin
				// usually a follow-up that should hit the stored receive time
				it = serve_item(pool[k], pool_rx[k]);
				if ($urandom_range(9) == 0)
					it.rtx = it.rrx;
			end else if (pick < 75) begin
				it = serve_item(pool[k], $urandom_range(1) ? rand64() : 64'd0);
			end else if (pick < 85) begin
				it = random_item();
			end else begin
				it = serve_item(pool[k], pool_rx[k]);
				case ($urandom_range(2))
					0: it.dest = own_now ^ ($urandom | 32'h1);
					1: it.client = own_now;
					default: it.mode = MODE_W'($urandom_range(6) + 4);
				endcase
			end
			send_item(it);
			done++;
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] own_val;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		set_own(32'hC0A8_0101);
		directed();
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: own_val = '0;
				1: own_val = '1;
				4: own_val = 32'h0000_0001;
				default: own_val = $urandom;
			endcase
			set_idling(p % 4);
			set_own(own_val);
			new_pool();
			random_phase(PHASE_ITEMS, p == 2);
		end
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ ntp_interleaved_timestamp_table.f @@
src/ntit_pkg.sv
src/ntit_ram.sv
src/ntit_ctrl.sv
src/ntit_datapath.sv
src/ntp_interleaved_timestamp_table.sv
bench/ntp_reply_checker.sv
bench/tb_ntp_interleaved_timestamp_table.sv
